// ===== hdl/interleaved_float_accumulator_defines.svh =====
// assertion macros for the interleaved float accumulator
`ifndef INTERLEAVED_FLOAT_ACCUMULATOR_DEFINES_SVH
`define INTERLEAVED_FLOAT_ACCUMULATOR_DEFINES_SVH
// implication checked every clock, idle in reset
`define IFA_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);
// next-cycle implication
`define IFA_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);
`endif

// ===== hdl/ifa_pkg.sv =====
// ----------------------------------------------------------------------------
// ifa_pkg
// shared types, constants and float adder helpers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ifa_pkg;
   localparam int LANES_DEFAULT = 16;
   localparam logic [31:0] FP_ZERO = 32'h0000_0000;
   localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
   localparam logic [0:0] REG_PATHS = 1'b0;
   localparam logic [0:0] REG_STEPS = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic add_in;     // add input into current slot
      logic clr_total;  // load total with +0
      logic add_slot;   // total += slot[red_idx]
      logic clr_slots;  // clear all slots
      logic load_out;   // copy total to output register
   } cmd_type;

   // unpacked operand
   typedef struct packed {
      logic        sign;
      logic [9:0]  exp;   // biased, subnormal -> 1
      logic [26:0] man;   // hidden.23 frac.3 guard bits
   } unp_type;

   // stage 1 of the adder: align and add
   typedef struct packed {
      logic        special;
      logic [31:0] special_bits;
      logic        sign;
      logic [9:0]  exp;
      logic [27:0] mag;
      logic        zero_sign;
   } add1_type;

   function automatic logic [4:0] lzc28(input logic [27:0] v);
      logic [4:0] n;
      logic       found;
      n = 5'd28;
      found = 1'b0;
      for (int i = 27; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 5'(27 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // first half: specials, alignment with sticky, signed magnitude add
   function automatic add1_type fadd_s1(input logic [31:0] a, input logic [31:0] b);
      add1_type r;
      logic [7:0] ea, eb;
      logic [22:0] fa, fb;
      logic a_nan, b_nan, a_inf, b_inf;
      logic [9:0] xa, xb, d;
      logic [26:0] ma, mb, big, sml, sh;
      logic sbig, ssml, stk;
      logic [9:0] ebig;
      ea = a[30:23]; eb = b[30:23]; fa = a[22:0]; fb = b[22:0];
      a_nan = (ea == 8'hFF) && (fa != 23'd0);
      b_nan = (eb == 8'hFF) && (fb != 23'd0);
      a_inf = (ea == 8'hFF) && (fa == 23'd0);
      b_inf = (eb == 8'hFF) && (fb == 23'd0);
      r = '0;
      r.zero_sign = a[31] & b[31];
      if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
         r.special = 1'b1; r.special_bits = FP_QNAN;
      end else if (a_inf) begin
         r.special = 1'b1; r.special_bits = a;
      end else if (b_inf) begin
         r.special = 1'b1; r.special_bits = b;
      end
      xa = (ea == 8'd0) ? 10'd1 : {2'b00, ea};
      xb = (eb == 8'd0) ? 10'd1 : {2'b00, eb};
      ma = {(ea != 8'd0), fa, 3'b000};
      mb = {(eb != 8'd0), fb, 3'b000};
      if ({xa, ma} >= {xb, mb}) begin
         big = ma; sml = mb; sbig = a[31]; ssml = b[31]; ebig = xa; d = xa - xb;
      end else begin
         big = mb; sml = ma; sbig = b[31]; ssml = a[31]; ebig = xb; d = xb - xa;
      end
      if (d >= 10'd27) begin
         sh = '0; stk = (sml != 27'd0);
      end else begin
         sh = sml >> d;
         stk = ((sml & ~(27'h7FF_FFFF << d)) != 27'd0);
      end
      sh[0] = sh[0] | stk;
      r.sign = sbig;
      r.exp = ebig;
      if (sbig == ssml) r.mag = {1'b0, big} + {1'b0, sh};
      else r.mag = {1'b0, big} - {1'b0, sh};
      return r;
   endfunction

   // second half: normalise, round to nearest even, pack
   function automatic logic [31:0] fadd_s2(input add1_type s);
      logic [4:0] lz;
      logic [27:0] m;
      logic [9:0] e;
      logic [9:0] shl;
      logic st;
      logic [24:0] rm;
      logic rnd;
      if (s.special) return s.special_bits;
      if (s.mag == 28'd0) return {s.zero_sign, 31'd0};
      m = s.mag; e = s.exp;
      if (m[27]) begin
         st = m[0]; m = m >> 1; m[0] = m[0] | st; e = e + 10'd1;
      end else begin
         lz = lzc28(m) - 5'd1;
         shl = (e - 10'd1 < {5'd0, lz}) ? e - 10'd1 : {5'd0, lz};
         m = m << shl; e = e - shl;
      end
      // m[26] hidden, m[25:3] frac, m[2:0] grs
      rnd = m[2] & (m[1] | m[0] | m[3]);
      rm = {1'b0, m[26:3]} + {24'd0, rnd};
      if (rm[24]) begin
         rm = rm >> 1; e = e + 10'd1;
      end
      if (!rm[23]) e = 10'd0;
      if (e >= 10'd255) return {s.sign, 8'hFF, 23'd0};
      return {s.sign, e[7:0], rm[22:0]};
   endfunction
endpackage
`default_nettype wire

// ===== hdl/ifa_stream_if.sv =====
// ----------------------------------------------------------------------------
// ifa_stream_if
// valid/ready channels for data, results and register writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface ifa_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] value_bits;
   modport source (output valid, output value_bits, input ready);
   modport sink (input valid, input value_bits, output ready);
endinterface

interface ifa_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] sum_bits;
   logic        last_of_run;
   modport source (output valid, output sum_bits, output last_of_run, input ready);
   modport sink (input valid, input sum_bits, input last_of_run, output ready);
endinterface

interface ifa_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/ifa_datapath.sv =====
// ----------------------------------------------------------------------------
// ifa_datapath
// slot registers, two-stage float adder, total and output registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ifa_datapath #(
   parameter int LANES = ifa_pkg::LANES_DEFAULT
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire ifa_pkg::cmd_type                         cmd,
   input  wire logic [31:0]                              value_bits,
   input  wire logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] slot_idx,
   input  wire logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] red_idx,
   output logic [31:0]                                   sum_bits
);
   localparam int IW = (LANES > 1) ? $clog2(LANES) : 1;
   logic [31:0] slot_ff [LANES];
   logic [31:0] total_ff;
   logic [31:0] sum_ff;
   ifa_pkg::add1_type s1_ff;
   logic [31:0] opa, opb;
   logic add_v_ff, slot_v_ff;
   logic [IW-1:0] wr_idx_ff;

   // stage one operands: input slot or reduction
   always_comb begin
      if (cmd.add_slot) begin
         opa = total_ff; opb = slot_ff[red_idx[IW-1:0]];
      end else begin
         opa = slot_ff[slot_idx[IW-1:0]]; opb = value_bits;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff     <= ifa_pkg::fadd_s1(opa, opb);
      wr_idx_ff <= slot_idx;
      if (reset) begin
         add_v_ff  <= 1'b0;
         slot_v_ff <= 1'b0;
      end else begin
         add_v_ff  <= cmd.add_in;
         slot_v_ff <= cmd.add_slot;
      end
      if (reset || cmd.clr_slots) begin
         for (int i = 0; i < LANES; i++) slot_ff[i] <= ifa_pkg::FP_ZERO;
      end else if (add_v_ff) begin
         slot_ff[wr_idx_ff] <= ifa_pkg::fadd_s2(s1_ff);
      end
      if (cmd.clr_total) total_ff <= ifa_pkg::FP_ZERO;
      else if (slot_v_ff) total_ff <= ifa_pkg::fadd_s2(s1_ff);
      if (cmd.load_out) sum_ff <= total_ff;
   end

   assign sum_bits = sum_ff;
endmodule
`default_nettype wire

// ===== hdl/ifa_controller.sv =====
// ----------------------------------------------------------------------------
// ifa_controller
// handshakes, counters and sequencing of adds and the slot reduction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ifa_controller #(
   parameter int LANES = ifa_pkg::LANES_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_last,
   input  wire logic                       csr_valid,
   input  wire logic [0:0]                 csr_index,
   input  wire logic [31:0]                csr_data,
   output ifa_pkg::cmd_type                cmd,
   output logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] slot_idx,
   output logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] red_idx
);
   localparam int IW = (LANES > 1) ? $clog2(LANES) : 1;
   localparam logic [IW-1:0] LAST_SLOT = IW'(LANES - 1);
   localparam logic [2:0] ST_IDLE = 3'd0, ST_ADD = 3'd1, ST_RED = 3'd2,
                          ST_WAIT = 3'd3, ST_OUT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [31:0] paths_ff, steps_ff, pcount_ff, pcount_in, scount_ff, scount_in;
   logic [IW-1:0] slot_ff, slot_in, red_ff, red_in;
   logic close_ff, close_in, last_ff, last_in, rv_ff, rv_in;
   logic [31:0] np, ns;
   logic acc;

   assign np = pcount_ff + 32'd1;
   assign ns = scount_ff + 32'd1;
   // new value waits for the adder write-back of the previous one
   assign req_ready = (state_ff == ST_IDLE);
   assign acc = req_valid && req_ready;

   always_comb begin
      state_in = state_ff; pcount_in = pcount_ff; scount_in = scount_ff;
      slot_in = slot_ff; red_in = red_ff; close_in = close_ff;
      last_in = last_ff; rv_in = rv_ff && !rsp_ready;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               cmd.add_in = 1'b1;
               slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + IW'(1);
               close_in = (np == 32'd0) || (np >= paths_ff);
               pcount_in = close_in ? 32'd0 : np;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            // slot write-back happens this cycle
            if (close_ff) begin
               cmd.clr_total = 1'b1;
               red_in = '0;
               state_in = ST_RED;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RED: begin
            cmd.add_slot = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (red_ff == LAST_SLOT) begin
               state_in = ST_OUT;
            end else begin
               red_in = red_ff + IW'(1);
               state_in = ST_RED;
            end
         end
         ST_OUT: begin
            if (!rv_ff) begin
               cmd.load_out = 1'b1;
               cmd.clr_slots = 1'b1;
               slot_in = '0;
               last_in = (ns == 32'd0) || (ns >= steps_ff);
               scount_in = last_in ? 32'd0 : ns;
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; paths_ff <= 32'd1; steps_ff <= 32'd1;
         pcount_ff <= '0; scount_ff <= '0; slot_ff <= '0; red_ff <= '0;
         close_ff <= 1'b0; last_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pcount_ff <= pcount_in; scount_ff <= scount_in;
         slot_ff <= slot_in; red_ff <= red_in; close_ff <= close_in;
         last_ff <= last_in; rv_ff <= rv_in;
         if (csr_valid) begin
            if (csr_index == ifa_pkg::REG_PATHS) paths_ff <= csr_data;
            else steps_ff <= csr_data;
         end
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_last = last_ff;
   assign slot_idx = slot_ff;
   assign red_idx = red_ff;
endmodule
`default_nettype wire

// ===== hdl/interleaved_float_accumulator.sv =====
// ----------------------------------------------------------------------------
// interleaved_float_accumulator
// single-precision accumulator over interleaved partial sums
// ----------------------------------------------------------------------------
// req: one float value per transfer, added into slot k mod LANES of its group.
// rsp: one total per group of paths_per_step values, with last_of_run set on
//      the last total of each run of steps_per_run totals.
// csr: index 0 writes paths_per_step, index 1 steps_per_run; always ready;
//      must be written only while idle; the block does not enforce it.
// a value that does not close its group is followed by ADD, where req is not
// ready: the two-stage slot adder's write-back must land before the next read.
// a closing value is followed by the reduction, which runs the slots one at a
// time through the same two-stage adder (RED then WAIT per slot), then by OUT,
// where the total is loaded and rsp valid is registered.
// reset: slots +0, counters 0, both registers 1, no result pending.
// a stalled rsp holds its total in the output register; values are still taken,
// but after a closing value the new total waits in OUT until the old one leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module interleaved_float_accumulator #(
   parameter int LANES = ifa_pkg::LANES_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   ifa_req_if.sink  req,
   ifa_rsp_if.source rsp,
   ifa_csr_if.sink  csr
);
   localparam int IW = (LANES > 1) ? $clog2(LANES) : 1;
   ifa_pkg::cmd_type cmd;
   logic [IW-1:0] slot_idx, red_idx;

   assign csr.ready = 1'b1;

   ifa_controller #(.LANES(LANES)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_last(rsp.last_of_run),
      .csr_valid(csr.valid), .csr_index(csr.index), .csr_data(csr.data),
      .cmd(cmd), .slot_idx(slot_idx), .red_idx(red_idx)
   );

   ifa_datapath #(.LANES(LANES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .value_bits(req.value_bits),
      .slot_idx(slot_idx), .red_idx(red_idx), .sum_bits(rsp.sum_bits)
   );
endmodule
`default_nettype wire

// ===== hdl/ifa_checker.sv =====
// ----------------------------------------------------------------------------
// ifa_checker
// port-level checks on the accumulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "interleaved_float_accumulator_defines.svh"
module ifa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_sum_bits
);
   `IFA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sum_bits), "rsp changed while stalled")
   `IFA_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid && rsp_ready, !rsp_valid, "rsp repeated")
   `IFA_ASSERT_NEXT(a_gap_after_take, clock, reset, req_valid && req_ready, !req_ready, "adjacent transfers")
   `IFA_ASSERT_IMP(a_rsp_from_out, clock, reset, $rose(rsp_valid), $past(!req_ready), "rsp while idle")
endmodule

bind interleaved_float_accumulator ifa_checker u_ifa_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_sum_bits(rsp.sum_bits)
);
`default_nettype wire
